// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/pbpg_pkg.sv -----
package pbpg_pkg;

   localparam int DIM_W   = 13;
   localparam int INSET_W = 11;
   localparam int PIX_W   = 12;
   localparam int EXT_W   = DIM_W + 1;

   typedef logic [DIM_W-1:0] dim_type;
   typedef logic [INSET_W-1:0] inset_type;
   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [1:0] region_type;
   typedef logic [2:0] csr_index_type;
   typedef logic [31:0] color_type;

   localparam region_type REGION_OUTER  = 2'd0;
   localparam region_type REGION_BORDER = 2'd1;
   localparam region_type REGION_INNER  = 2'd2;
   localparam region_type REGION_BAR    = 2'd3;

   localparam csr_index_type CSR_FRAME_WIDTH      = 3'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT     = 3'd1;
   localparam csr_index_type CSR_BORDER_INSET     = 3'd2;
   localparam csr_index_type CSR_BORDER_THICKNESS = 3'd3;
   localparam csr_index_type CSR_BAR_GAP          = 3'd4;
   localparam csr_index_type CSR_VERTICAL_MODE    = 3'd5;
   localparam csr_index_type CSR_FILL_LEVEL       = 3'd6;

   localparam color_type BG_COLOR   = 32'hFF33_3333;
   localparam color_type FILL_SHADE = 32'hFF00_AA00;
   localparam color_type RIM_SHADE  = 32'hFFFF_FFFF;

   localparam dim_type   FRAME_WIDTH_RST  = 13'd400;
   localparam dim_type   FRAME_HEIGHT_RST = 13'd50;
   localparam inset_type INSET_RST        = 11'd4;

   function automatic color_type region_color(input region_type r);
      color_type c;
      case (r)
         REGION_BORDER: c = RIM_SHADE;
         REGION_BAR:    c = FILL_SHADE;
         default:       c = BG_COLOR;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/progress_bar_pixel_generator.sv -----
// Progress bar pixel generator: one pixel coordinate in, its ARGB8888 color and region out,
// one beat per clock while the result side is ready and no CSR write settles. A beat passes
// through the input register, then the result register; a stalled result register still
// lets an empty input register take a beat. Geometry (layer insets, layer bounds, bar
// length) is precomputed from the CSRs by a four-stage pipeline holding the bar-length
// multiplier; req_ready stays low in the cycle of a CSR write and while the settle counter
// set by writes and reset runs down. CSR writes are expected only with no beat in flight.
`include "assert_macros.svh"

module progress_bar_pixel_generator #(
   parameter int MAX_DIM        = 4096,
   parameter int FILL_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pbpg_pkg::pix_type                    req_pixel_x,
   input  pbpg_pkg::pix_type                    req_pixel_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pbpg_pkg::color_type                  rsp_pixel_color,
   output pbpg_pkg::region_type                 rsp_region,
   input  logic                                 csr_write_en,
   input  pbpg_pkg::csr_index_type              csr_index,
   input  logic [((FILL_FRAC_BITS + 1 > pbpg_pkg::DIM_W) ?
                  FILL_FRAC_BITS + 1 : pbpg_pkg::DIM_W) - 1:0] csr_wdata
);
   import pbpg_pkg::*;

   localparam int FILL_W = FILL_FRAC_BITS + 1;
   localparam int PROD_W = DIM_W + FILL_W;
   localparam int SETTLE_CYC = 4;
   localparam logic [2:0] SETTLE_INIT = 3'(SETTLE_CYC);
   localparam dim_type DIM_CAP = DIM_W'(MAX_DIM);
   localparam logic [FILL_W-1:0] FILL_ONE = {1'b1, {FILL_FRAC_BITS{1'b0}}};

   // CSRs
   dim_type            frame_width_ff, frame_width_in;
   dim_type            frame_height_ff, frame_height_in;
   inset_type          border_inset_ff, border_inset_in;
   inset_type          border_thickness_ff, border_thickness_in;
   inset_type          bar_gap_ff, bar_gap_in;
   logic               vertical_mode_ff, vertical_mode_in;
   logic [FILL_W-1:0]  fill_level_ff, fill_level_in;
   logic [2:0]         settle_ff, settle_in;

   always_comb begin
      frame_width_in      = frame_width_ff;
      frame_height_in     = frame_height_ff;
      border_inset_in     = border_inset_ff;
      border_thickness_in = border_thickness_ff;
      bar_gap_in          = bar_gap_ff;
      vertical_mode_in    = vertical_mode_ff;
      fill_level_in       = fill_level_ff;
      settle_in           = (settle_ff != 3'd0) ? settle_ff - 3'd1 : settle_ff;
      if (csr_write_en) begin
         settle_in = SETTLE_INIT;
         unique case (csr_index)
            CSR_FRAME_WIDTH:
               frame_width_in = (32'(csr_wdata[DIM_W-1:0]) > MAX_DIM) ? DIM_CAP
                                                                      : csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:
               frame_height_in = (32'(csr_wdata[DIM_W-1:0]) > MAX_DIM) ? DIM_CAP
                                                                       : csr_wdata[DIM_W-1:0];
            CSR_BORDER_INSET:     border_inset_in     = csr_wdata[INSET_W-1:0];
            CSR_BORDER_THICKNESS: border_thickness_in = csr_wdata[INSET_W-1:0];
            CSR_BAR_GAP:          bar_gap_in          = csr_wdata[INSET_W-1:0];
            CSR_VERTICAL_MODE:    vertical_mode_in    = csr_wdata[0];
            CSR_FILL_LEVEL:       fill_level_in       = csr_wdata[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff      <= FRAME_WIDTH_RST;
         frame_height_ff     <= FRAME_HEIGHT_RST;
         border_inset_ff     <= INSET_RST;
         border_thickness_ff <= INSET_RST;
         bar_gap_ff          <= INSET_RST;
         vertical_mode_ff    <= 1'b0;
         fill_level_ff       <= '0;
         settle_ff           <= SETTLE_INIT;
      end else begin
         frame_width_ff      <= frame_width_in;
         frame_height_ff     <= frame_height_in;
         border_inset_ff     <= border_inset_in;
         border_thickness_ff <= border_thickness_in;
         bar_gap_ff          <= bar_gap_in;
         vertical_mode_ff    <= vertical_mode_in;
         fill_level_ff       <= fill_level_in;
         settle_ff           <= settle_in;
      end
   end

   // geometry pipeline, stage 1: layer insets, saturated fill
   dim_type            o1_ff, o1_in, o2_ff, o2_in, o3_ff, o3_in;
   logic [FILL_W-1:0]  fsat_ff, fsat_in;

   assign o1_in   = DIM_W'(border_inset_ff);
   assign o2_in   = o1_in + DIM_W'(border_thickness_ff);
   assign o3_in   = o2_in + DIM_W'(bar_gap_ff);
   assign fsat_in = (fill_level_ff > FILL_ONE) ? FILL_ONE : fill_level_ff;

   // stage 2: layer existence, upper bounds, bar extents
   logic     ex1_ff, ex1_in, ex2_ff, ex2_in, ex3_ff, ex3_in;
   dim_type  hx1_ff, hx1_in, hx2_ff, hx2_in, hx3_ff, hx3_in;
   dim_type  hy1_ff, hy1_in, hy2_ff, hy2_in, hy3_ff, hy3_in;
   dim_type  bar_ext_ff, bar_ext_in;
   logic [EXT_W-1:0] fw_ext, fh_ext, bw_full, bh_full;

   always_comb begin
      fw_ext  = {1'b0, frame_width_ff};
      fh_ext  = {1'b0, frame_height_ff};
      ex1_in  = ({o1_ff, 1'b0} < fw_ext) && ({o1_ff, 1'b0} < fh_ext);
      ex2_in  = ({o2_ff, 1'b0} < fw_ext) && ({o2_ff, 1'b0} < fh_ext);
      ex3_in  = ({o3_ff, 1'b0} < fw_ext) && ({o3_ff, 1'b0} < fh_ext);
      hx1_in  = frame_width_ff - o1_ff;
      hx2_in  = frame_width_ff - o2_ff;
      hx3_in  = frame_width_ff - o3_ff;
      hy1_in  = frame_height_ff - o1_ff;
      hy2_in  = frame_height_ff - o2_ff;
      hy3_in  = frame_height_ff - o3_ff;
      bw_full = fw_ext - {o3_ff, 1'b0};
      bh_full = fh_ext - {o3_ff, 1'b0};
      bar_ext_in = vertical_mode_ff ? bh_full[DIM_W-1:0] : bw_full[DIM_W-1:0];
   end

   // stage 3: bar length
   dim_type            bar_len_ff, bar_len_in;
   logic [PROD_W-1:0]  bar_prod;

   assign bar_prod   = PROD_W'(bar_ext_ff) * PROD_W'(fsat_ff);
   assign bar_len_in = bar_prod[FILL_FRAC_BITS +: DIM_W];

   // stage 4: bar edge; x below it (horizontal) or y at or above it (vertical)
   dim_type bar_edge_ff, bar_edge_in;

   assign bar_edge_in = vertical_mode_ff ? (hy3_ff - bar_len_ff) : (o3_ff + bar_len_ff);

   always_ff @(posedge clock) begin
      o1_ff       <= o1_in;
      o2_ff       <= o2_in;
      o3_ff       <= o3_in;
      fsat_ff     <= fsat_in;
      ex1_ff      <= ex1_in;
      ex2_ff      <= ex2_in;
      ex3_ff      <= ex3_in;
      hx1_ff      <= hx1_in;
      hx2_ff      <= hx2_in;
      hx3_ff      <= hx3_in;
      hy1_ff      <= hy1_in;
      hy2_ff      <= hy2_in;
      hy3_ff      <= hy3_in;
      bar_ext_ff  <= bar_ext_in;
      bar_len_ff  <= bar_len_in;
      bar_edge_ff <= bar_edge_in;
   end

   // beat pipeline: input register, result register
   logic        s1_valid_ff, s1_valid_in;
   pix_type     s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   color_type   rsp_color_ff, rsp_color_in;
   region_type  rsp_region_ff, rsp_region_in;
   logic        out_adv, req_take;
   dim_type     px, py;
   logic        in_frame, l1, l2, l3, on_bar;
   region_type  region;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (!s1_valid_ff || out_adv) && (settle_ff == 3'd0) && !csr_write_en;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      px       = {1'b0, s1_x_ff};
      py       = {1'b0, s1_y_ff};
      in_frame = (px < frame_width_ff) && (py < frame_height_ff);
      l1 = ex1_ff && (px >= o1_ff) && (px < hx1_ff) && (py >= o1_ff) && (py < hy1_ff);
      l2 = ex2_ff && (px >= o2_ff) && (px < hx2_ff) && (py >= o2_ff) && (py < hy2_ff);
      l3 = ex3_ff && (px >= o3_ff) && (px < hx3_ff) && (py >= o3_ff) && (py < hy3_ff);
      on_bar = vertical_mode_ff ? (py >= bar_edge_ff) : (px < bar_edge_ff);
      region = REGION_OUTER;
      if (in_frame) begin
         if (l1) region = REGION_BORDER;
         if (l2) region = REGION_INNER;
         if (l3) region = on_bar ? REGION_BAR : REGION_INNER;
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_x_in       = s1_x_ff;
      s1_y_in       = s1_y_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_region_in = rsp_region_ff;
      if (out_adv) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_color_in  = region_color(region);
         rsp_region_in = region;
         s1_valid_in   = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_x_in     = req_pixel_x;
         s1_y_in     = req_pixel_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_x_ff       <= s1_x_in;
      s1_y_ff       <= s1_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_region      = rsp_region_ff;

   `ASSERT_IMPLIES(a_border_color, clock, reset, rsp_valid_ff,
      (rsp_region_ff == REGION_BORDER) == (rsp_color_ff == RIM_SHADE))
   `ASSERT_NEXT(a_take_loads_s1, clock, reset, req_take, s1_valid_ff)
   `ASSERT_IMPLIES(a_bar_in_layer, clock, reset,
      (settle_ff == 3'd0) && ex3_ff && !vertical_mode_ff, bar_edge_ff <= hx3_ff)

endmodule

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pbpg_pkg::*;

   localparam int WDATA_W = 17;
   localparam int DIM_LIMIT = 4096;
   localparam int FRAC_BITS = 16;
   localparam longint unsigned FILL_ONE = 64'd1 << FRAC_BITS;
   localparam int PHASES = 8;
   localparam int PHASE_PIXELS = 48;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam csr_index_type CSR_UNUSED = 3'd7;

   typedef struct packed {
      color_type  color;
      region_type region;
   } pixel_result_type;

   typedef struct packed {
      bit                   is_csr;
      csr_index_type        index;
      logic [WDATA_W-1:0]   value;
      pix_type              x;
      pix_type              y;
      bit                   known;
      region_type           region;
   } stim_row_type;

   typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_pattern_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   pix_type              req_pixel_x;
   pix_type              req_pixel_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   color_type            rsp_pixel_color;
   region_type           rsp_region;
   logic                 csr_write_en;
   csr_index_type        csr_index;
   logic [WDATA_W-1:0]   csr_wdata;

   // shadow copy of the geometry registers
   longint unsigned frame_w;
   longint unsigned frame_h;
   longint unsigned border_inset;
   longint unsigned border_thickness;
   longint unsigned bar_gap;
   bit              vertical_mode;
   longint unsigned fill_level;

   pixel_result_type expected_pixels[$];
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               burst_left = 0;
   int unsigned      cycle_count = 0;
   bit               holdoff_req = 0;

   progress_bar_pixel_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_region      (rsp_region),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic color_type shade_of(input region_type r);
      case (r)
         REGION_BORDER: return 32'hFFFF_FFFF;
         REGION_BAR:    return 32'hFF00_AA00;
         default:       return 32'hFF33_3333;
      endcase
   endfunction

   function automatic longint unsigned clamp_dim(input logic [WDATA_W-1:0] v);
      longint unsigned d;
      d = 64'(v & 17'h1FFF);
      return (d > DIM_LIMIT) ? 64'(DIM_LIMIT) : d;
   endfunction

   function automatic bit covers(input longint unsigned x, input longint unsigned y,
                                 input longint unsigned o);
      if (2 * o >= frame_w || 2 * o >= frame_h)
         return 1'b0;
      return x >= o && x < frame_w - o && y >= o && y < frame_h - o;
   endfunction

   function automatic pixel_result_type predict_pixel(input pix_type x, input pix_type y);
      longint unsigned o1, o2, o3, f, bw, bh, bar_len, px, py;
      region_type r;
      px = 64'(x);
      py = 64'(y);
      o1 = border_inset;
      o2 = o1 + border_thickness;
      o3 = o2 + bar_gap;
      r = REGION_OUTER;
      if (px < frame_w && py < frame_h) begin
         if (covers(px, py, o1))
            r = REGION_BORDER;
         if (covers(px, py, o2))
            r = REGION_INNER;
         if (covers(px, py, o3)) begin
            f = (fill_level > FILL_ONE) ? FILL_ONE : fill_level;
            bw = frame_w - 2 * o3;
            bh = frame_h - 2 * o3;
            if (!vertical_mode) begin
               bar_len = (bw * f) >> FRAC_BITS;
               if (px - o3 < bar_len)
                  r = REGION_BAR;
            end else begin
               bar_len = (bh * f) >> FRAC_BITS;
               if (py - o3 >= bh - bar_len)
                  r = REGION_BAR;
            end
         end
      end
      return '{color: shade_of(r), region: r};
   endfunction

   function automatic stim_row_type pixel_row(input pix_type x, input pix_type y);
      return '{is_csr: 1'b0, index: CSR_FRAME_WIDTH, value: '0, x: x, y: y,
               known: 1'b0, region: REGION_OUTER};
   endfunction

   function automatic stim_row_type known_row(input pix_type x, input pix_type y,
                                              input region_type r);
      return '{is_csr: 1'b0, index: CSR_FRAME_WIDTH, value: '0, x: x, y: y,
               known: 1'b1, region: r};
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type i,
                                            input logic [WDATA_W-1:0] v);
      return '{is_csr: 1'b1, index: i, value: v, x: '0, y: '0,
               known: 1'b0, region: REGION_OUTER};
   endfunction

   task automatic write_csr(input csr_index_type i, input logic [WDATA_W-1:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      case (i)
         CSR_FRAME_WIDTH:      frame_w = clamp_dim(v);
         CSR_FRAME_HEIGHT:     frame_h = clamp_dim(v);
         CSR_BORDER_INSET:     border_inset = 64'(v & 17'h7FF);
         CSR_BORDER_THICKNESS: border_thickness = 64'(v & 17'h7FF);
         CSR_BAR_GAP:          bar_gap = 64'(v & 17'h7FF);
         CSR_VERTICAL_MODE:    vertical_mode = v[0];
         CSR_FILL_LEVEL:       fill_level = 64'(v);
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_pixel(input pix_type x, input pix_type y, input bit known,
                             input region_type r);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         idle = $urandom_range(0, 10);
         if (idle > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (idle - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (!req_ready);
      if (known)
         expected_pixels.push_back('{color: shade_of(r), region: r});
      else
         expected_pixels.push_back(predict_pixel(x, y));
   endtask

   function automatic logic [WDATA_W-1:0] pick_inset();
      if ($urandom_range(0, 7) == 0)
         return WDATA_W'($urandom_range(0, 17'h1FFFF));
      return WDATA_W'($urandom_range(0, 10));
   endfunction

   function automatic pix_type pick_coord(input longint unsigned dim);
      longint unsigned hi;
      if ($urandom_range(0, 3) == 0)
         return PIX_W'($urandom_range(0, 4095));
      hi = (dim + 2 > 4095) ? 4095 : dim + 2;
      return PIX_W'($urandom_range(0, 32'(hi)));
   endfunction

   task automatic setup_phase(input int phase);
      logic [WDATA_W-1:0] w, h, f;
      if (phase == 0) begin
         w = WDATA_W'(DIM_LIMIT);
         h = WDATA_W'(DIM_LIMIT);
      end else if (phase == PHASES - 1) begin
         w = WDATA_W'($urandom_range(1, 3));
         h = WDATA_W'($urandom_range(1, 3));
      end else begin
         w = ($urandom_range(0, 7) == 0) ? WDATA_W'($urandom_range(0, 17'h1FFFF))
                                         : WDATA_W'($urandom_range(1, 96));
         h = ($urandom_range(0, 7) == 0) ? WDATA_W'($urandom_range(0, 17'h1FFFF))
                                         : WDATA_W'($urandom_range(1, 96));
      end
      case ($urandom_range(0, 4))
         0:       f = 17'd0;
         1:       f = 17'd65536;
         2:       f = WDATA_W'($urandom_range(65537, 17'h1FFFF));
         default: f = WDATA_W'($urandom_range(0, 65536));
      endcase
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_BORDER_INSET, pick_inset());
      write_csr(CSR_BORDER_THICKNESS, pick_inset());
      write_csr(CSR_BAR_GAP, pick_inset());
      write_csr(CSR_VERTICAL_MODE, WDATA_W'($urandom_range(0, 1)));
      write_csr(CSR_FILL_LEVEL, f);
      if (phase % 2 == 1)
         write_csr(CSR_UNUSED, WDATA_W'($urandom_range(0, 17'h1FFFF)));
   endtask

   // result side: own stall pattern plus one long hold-off on request
   initial begin
      rx_pattern_type pattern;
      int             hold;
      int unsigned    tick;
      pattern = RX_ALWAYS;
      hold = 0;
      tick = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            hold = HOLDOFF_CYCLES;
         end
         if (tick % 64 == 0)
            pattern = rx_pattern_type'($urandom_range(0, 3));
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            case (pattern)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= tick[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: color %h region %0d", rsp_pixel_color, rsp_region);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_color !== want.color || rsp_region !== want.region) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: color exp %h got %h, region exp %0d got %0d",
                           want.color, rsp_pixel_color, want.region, rsp_region);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      frame_w = 400;
      frame_h = 50;
      border_inset = 4;
      border_thickness = 4;
      bar_gap = 4;
      vertical_mode = 1'b0;
      fill_level = 0;

      directed_rows.push_back(known_row(12'd0, 12'd0, REGION_OUTER));
      directed_rows.push_back(known_row(12'd4, 12'd4, REGION_BORDER));
      directed_rows.push_back(known_row(12'd8, 12'd8, REGION_INNER));
      directed_rows.push_back(known_row(12'd12, 12'd12, REGION_INNER));
      directed_rows.push_back(known_row(12'd4095, 12'd4095, REGION_OUTER));
      directed_rows.push_back(csr_row(CSR_FILL_LEVEL, 17'd65536));
      directed_rows.push_back(known_row(12'd12, 12'd12, REGION_BAR));
      directed_rows.push_back(known_row(12'd387, 12'd37, REGION_BAR));
      directed_rows.push_back(csr_row(CSR_FILL_LEVEL, 17'h1FFFF));
      directed_rows.push_back(known_row(12'd387, 12'd25, REGION_BAR));
      directed_rows.push_back(csr_row(CSR_VERTICAL_MODE, 17'd1));
      directed_rows.push_back(csr_row(CSR_FILL_LEVEL, 17'd32768));
      directed_rows.push_back(pixel_row(12'd20, 12'd37));
      directed_rows.push_back(pixel_row(12'd20, 12'd12));
      directed_rows.push_back(csr_row(CSR_UNUSED, 17'd0));
      directed_rows.push_back(pixel_row(12'd20, 12'd37));
      directed_rows.push_back(csr_row(CSR_BORDER_INSET, 17'd2047));
      directed_rows.push_back(pixel_row(12'd200, 12'd25));
      directed_rows.push_back(csr_row(CSR_BORDER_INSET, 17'd0));
      directed_rows.push_back(csr_row(CSR_BORDER_THICKNESS, 17'd0));
      directed_rows.push_back(csr_row(CSR_BAR_GAP, 17'd0));
      directed_rows.push_back(csr_row(CSR_FILL_LEVEL, 17'd65536));
      directed_rows.push_back(pixel_row(12'd0, 12'd0));
      directed_rows.push_back(csr_row(CSR_FRAME_WIDTH, 17'd8191));
      directed_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 17'd0));
      directed_rows.push_back(known_row(12'd0, 12'd0, REGION_OUTER));
      directed_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 17'd4096));
      directed_rows.push_back(pixel_row(12'd4095, 12'd4095));
      directed_rows.push_back(pixel_row(12'd4095, 12'd0));
      directed_rows.push_back(csr_row(CSR_FRAME_WIDTH, 17'd1));
      directed_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 17'd1));
      directed_rows.push_back(pixel_row(12'd0, 12'd0));
      directed_rows.push_back(pixel_row(12'd1, 12'd0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            wait_drained();
            write_csr(row.index, row.value);
         end else begin
            send_pixel(row.x, row.y, row.known, row.region);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         setup_phase(phase);
         if (phase == 2)
            holdoff_req = 1'b1;
         for (int n = 0; n < PHASE_PIXELS; n++)
            send_pixel(pick_coord(frame_w), pick_coord(frame_h), 1'b0, REGION_OUTER);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pbpg_pkg.sv
hw/rtl/progress_bar_pixel_generator.sv
bench/testbench.sv
